// ===== sv/ffbp_pkg.sv =====
// Shared types and constants for the first-fit bin packer.
`timescale 1ns / 1ps
`default_nettype none

package ffbp_pkg;

  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned BIN_W    = 9;

  localparam logic [WEIGHT_W-1:0] CAPACITY_ONE = 17'd65536;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_FULL      = 2'd1,
    ST_TOO_HEAVY = 2'd2
  } status_e;

  typedef struct packed {
    logic                valid;
    logic                done;
    logic                opened;
    logic [WEIGHT_W-1:0] weight;
    logic [BIN_W-1:0]    bin;
    status_e             status;
  } pkt_t;

endpackage

`default_nettype wire

// ===== sv/ffbp_cell.sv =====
// One bin cell: holds a bin's remaining capacity and passes the item packet on.
`timescale 1ns / 1ps
`default_nettype none

module ffbp_cell #(
  parameter int unsigned BIN_IDX = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic [ffbp_pkg::WEIGHT_W-1:0] cap_i,
  input  wire ffbp_pkg::pkt_t                pkt_i,
  output ffbp_pkg::pkt_t                     pkt_o
);
  import ffbp_pkg::*;

  localparam logic [BIN_W-1:0] BIN_NUM = BIN_W'(BIN_IDX + 1);

  logic                open_q, open_d;
  logic [WEIGHT_W-1:0] rem_q, rem_d;
  pkt_t                pkt_q, pkt_d;

  always_comb begin
    pkt_d  = pkt_i;
    rem_d  = rem_q;
    open_d = open_q;
    if (pkt_i.valid && !pkt_i.done) begin
      if (open_q) begin
        if (rem_q >= pkt_i.weight) begin
          rem_d        = rem_q - pkt_i.weight;
          pkt_d.done   = 1'b1;
          pkt_d.bin    = BIN_NUM;
          pkt_d.status = ST_PLACED;
        end
      end else begin
        open_d       = 1'b1;
        rem_d        = cap_i - pkt_i.weight;
        pkt_d.done   = 1'b1;
        pkt_d.opened = 1'b1;
        pkt_d.bin    = BIN_NUM;
        pkt_d.status = ST_PLACED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      pkt_q  <= '0;
    end else if (en_i) begin
      open_q <= open_d;
      pkt_q  <= pkt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

`default_nettype wire

// ===== sv/first_fit_bin_packer.sv =====
// Top level of the first-fit bin packer: input stage, chain of bin cells, output register.
// Each beat goes from the input register through one cell a cycle to the output register.
// Throughput is one beat per cycle; the whole chain advances together and stalls on m_axis_tready.
// Bins open in order as an item reaches the first unopened cell, so no clearing pass is needed.
// Reset closes every bin, empties the chain and sets the bin capacity to 65536 (1.0).
`timescale 1ns / 1ps
`default_nettype none

module first_fit_bin_packer #(
  parameter int unsigned MAX_BINS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i,    // capacity of a new bin
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [16:0] item_weight
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [8:0] bin_number, [9] opened_new, [11:10] status
);
  import ffbp_pkg::*;

  logic                en;
  logic [WEIGHT_W-1:0] cap_q;
  pkt_t                entry_d;
  pkt_t                entry_q;
  pkt_t                chain [MAX_BINS+1];
  logic                out_valid_q;
  logic [BIN_W-1:0]    out_bin_q;
  logic                out_opened_q;
  status_e             out_status_q;
  logic [WEIGHT_W-1:0] weight_in;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign weight_in     = s_axis_tdata[WEIGHT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_ONE;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    entry_d        = '0;
    entry_d.valid  = s_axis_tvalid;
    entry_d.weight = weight_in;
    if (weight_in > cap_q) begin
      entry_d.done   = 1'b1;
      entry_d.status = ST_TOO_HEAVY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en) begin
      entry_q <= entry_d;
    end
  end

  assign chain[0] = entry_q;

  for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
    ffbp_cell #(
      .BIN_IDX(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .cap_i (cap_q),
      .pkt_i (chain[k]),
      .pkt_o (chain[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[MAX_BINS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (chain[MAX_BINS].done) begin
        out_bin_q    <= chain[MAX_BINS].bin;
        out_opened_q <= chain[MAX_BINS].opened;
        out_status_q <= chain[MAX_BINS].status;
      end else begin
        out_bin_q    <= '0;
        out_opened_q <= 1'b0;
        out_status_q <= ST_FULL;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_status_q, out_opened_q, out_bin_q};

endmodule

`default_nettype wire

// ===== sim/first_fit_bin_packer_tb.sv =====
// Testbench for the first-fit bin packer: random stream traffic against a bin-level predictor.
`timescale 1ns / 1ps

module first_fit_bin_packer_tb;
  import ffbp_pkg::*;

  localparam int unsigned MAX_BINS = 256;

  typedef enum logic {
    JOB_WEIGHT,
    JOB_CAPACITY
  } job_kind_e;

  typedef struct {
    job_kind_e           kind;
    logic [WEIGHT_W-1:0] value;
  } job_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             opened;
    status_e          status;
  } placement_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  job_t                pending_jobs[$];
  placement_t          placements_due[$];
  logic [WEIGHT_W-1:0] bin_room[MAX_BINS];
  logic [WEIGHT_W-1:0] capacity_model = CAPACITY_ONE;
  int unsigned         bins_open = 0;
  int unsigned         error_count = 0;
  int unsigned         results_seen = 0;
  logic                weight_taken = 1'b0;
  int unsigned         send_gap = 0;
  int unsigned         send_burst = 0;
  int unsigned         stall_left = 0;
  int unsigned         recv_burst = 0;

  first_fit_bin_packer #(
    .MAX_BINS(MAX_BINS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic placement_t first_fit_place(input logic [WEIGHT_W-1:0] weight);
    placement_t  r;
    int unsigned k;
    r.bin = '0;
    r.opened = 1'b0;
    r.status = ST_PLACED;
    if (weight > capacity_model) begin
      r.status = ST_TOO_HEAVY;
      return r;
    end
    for (k = 0; k < bins_open; k++) begin
      if (bin_room[k] >= weight) begin
        bin_room[k] = bin_room[k] - weight;
        r.bin = BIN_W'(k + 1);
        return r;
      end
    end
    if (bins_open >= MAX_BINS) begin
      r.status = ST_FULL;
      return r;
    end
    bin_room[bins_open] = capacity_model - weight;
    bins_open++;
    r.bin = BIN_W'(bins_open);
    r.opened = 1'b1;
    return r;
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if (r < 2) begin
      burst = $urandom_range(20, 120);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WEIGHT_W-1:0] draw_weight(input logic [WEIGHT_W-1:0] cap);
    int unsigned r;
    int unsigned c;
    r = $urandom_range(0, 99);
    c = cap;
    if (r < 5) return '0;
    if (r < 10) return cap;
    if (r < 15) begin
      if (c >= 65536) return CAPACITY_ONE;
      return WEIGHT_W'($urandom_range(c + 1, 65536));
    end
    if (r < 55) return WEIGHT_W'($urandom_range(0, c / 8));
    return WEIGHT_W'($urandom_range(0, c));
  endfunction

  task automatic queue_weight(input logic [WEIGHT_W-1:0] weight);
    job_t j;
    j.kind = JOB_WEIGHT;
    j.value = weight;
    pending_jobs.push_back(j);
  endtask

  task automatic queue_capacity(input logic [WEIGHT_W-1:0] cap);
    job_t j;
    j.kind = JOB_CAPACITY;
    j.value = cap;
    pending_jobs.push_back(j);
  endtask

  task automatic report_mismatch(input string detail);
    error_count++;
    $display("[%0t] mismatch at result %0d: %s", $time, results_seen, detail);
  endtask

  // A capacity write waits until every placement already sent has come back.
  always @(negedge clk_i) begin : driver
    logic        next_valid;
    logic [23:0] next_data;
    logic        next_we;
    logic [16:0] next_cfg;
    next_valid = s_axis_tvalid;
    next_data = s_axis_tdata;
    next_we = 1'b0;
    next_cfg = cfg_wdata_i;
    if (rst_ni) begin
      if (s_axis_tvalid && weight_taken) next_valid = 1'b0;
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_jobs.size() != 0) begin
          if (pending_jobs[0].kind == JOB_WEIGHT) begin
            next_valid = 1'b1;
            next_data = {7'b0, pending_jobs[0].value};
            pending_jobs.delete(0);
            send_gap = pick_gap(send_burst);
          end else if (placements_due.size() == 0) begin
            next_we = 1'b1;
            next_cfg = pending_jobs[0].value;
            pending_jobs.delete(0);
            send_gap = pick_gap(send_burst);
          end
        end
      end
    end
    s_axis_tvalid <= next_valid;
    s_axis_tdata <= next_data;
    cfg_we_i <= next_we;
    cfg_wdata_i <= next_cfg;
  end

  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap(recv_burst);
    end
  end

  always @(posedge clk_i) begin : monitor
    placement_t seen;
    placement_t due;
    if (rst_ni) begin
      if (cfg_we_i) capacity_model = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        placements_due.push_back(first_fit_place(s_axis_tdata[16:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.bin = m_axis_tdata[8:0];
        seen.opened = m_axis_tdata[9];
        seen.status = status_e'(m_axis_tdata[11:10]);
        if (placements_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, tdata 0x%04h", m_axis_tdata));
        end else begin
          due = placements_due.pop_front();
          if (seen.bin !== due.bin) begin
            report_mismatch($sformatf("bin_number %0d, expected %0d", seen.bin, due.bin));
          end
          if (seen.opened !== due.opened) begin
            report_mismatch($sformatf("opened_new %0b, expected %0b", seen.opened,
                                      due.opened));
          end
          if (seen.status !== due.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", seen.status, due.status));
          end
        end
        results_seen++;
      end
    end
    weight_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  initial begin : sequencer
    logic [WEIGHT_W-1:0] cap;
    int unsigned         p;
    // Reset capacity: zero weight with no open bin, exact fills, odd bit patterns.
    queue_weight('0);
    queue_weight('0);
    queue_weight(CAPACITY_ONE);
    queue_weight(17'd1);
    queue_weight(17'd65535);
    queue_weight(CAPACITY_ONE);
    queue_weight('0);
    queue_weight(17'd43690);
    queue_weight(17'd21845);
    // Capacity of one: heavy items are rejected while open bins keep their room.
    queue_capacity(17'd1);
    queue_weight(17'd2);
    queue_weight(CAPACITY_ONE);
    queue_weight(17'd1);
    queue_weight(17'd1);
    queue_weight('0);
    // Zero capacity: only a zero weight is placed.
    queue_capacity('0);
    queue_weight('0);
    queue_weight(17'd1);
    queue_capacity(17'd65535);
    queue_weight(CAPACITY_ONE);
    queue_weight(17'd65535);
    queue_weight(17'd1);
    for (p = 0; p < 8; p++) begin
      case (p)
        0, 7: cap = CAPACITY_ONE;
        2: cap = WEIGHT_W'($urandom_range(1, 16));
        3: cap = 17'd65535;
        5: cap = 17'd32768;
        default: cap = WEIGHT_W'($urandom_range(1, 65536));
      endcase
      queue_capacity(cap);
      repeat (200) queue_weight(draw_weight(cap));
    end
    // Full-size items use up every bin until the packer runs out.
    queue_capacity(CAPACITY_ONE);
    repeat (MAX_BINS + 4) queue_weight(CAPACITY_ONE);
    repeat (60) queue_weight(draw_weight(CAPACITY_ONE));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_jobs.size() != 0 || s_axis_tvalid || placements_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (MAX_BINS + 16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("first_fit_bin_packer verification clean");
    end else begin
      $display("first_fit_bin_packer verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("first_fit_bin_packer verification failed");
    $finish;
  end

endmodule
